FILE: sv/tlpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_pkg: shared definitions for the three-level priority queue
// Sizes, action and level codes, queue status type and pointer helper.
// ----------------------------------------------------------------------------
package tlpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int WORD_BITS   = 32;
	localparam int FIELD_BITS  = 32;
	localparam int DATA_W      = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_LEVELS  = 3;
	localparam int CTR_W       = 32;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		LVL_HIGH = 2'd0,
		LVL_MID  = 2'd1,
		LVL_LOW  = 2'd2
	} level_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/tlpq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_fifo: one priority level's packet queue
// Circular register file with head and tail pointers and a fill count.
// ----------------------------------------------------------------------------
module tlpq_fifo import tlpq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              pop,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata,
	output fifo_stat_t        stat
);

	logic [DATA_W-1:0] store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[tail_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				tail_q <= next_ptr(tail_q);
			end
			if (pop) begin
				head_q <= next_ptr(head_q);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign rdata      = store_q[head_q];
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == CNT_W'(QUEUE_DEPTH));

endmodule
`default_nettype wire

FILE: sv/three_level_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_queue_top: strict-priority queue of packet words
// Request channel (req_valid/req_stall) carries action, priority_req and
// payload. A push stores the word in the high, mid or low queue; a pop takes
// the oldest word of the highest non-empty queue; a clear zeroes the counters;
// a read only reports them. Each request transaction yields exactly one
// response transaction on rsp_valid/rsp_stall with ok, payload_out,
// served_level and the four counters after the update.
// A request is registered on acceptance and processed into the response
// register when that register is free, and one transaction is taken every
// cycle while rsp_stall does not hold the response. The queue pointers and
// fill counts are updated between the request and response registers.
// When rsp_stall holds the response, the registered request waits and
// req_stall rises until the response is taken; no state changes meanwhile.
// Reset empties all queues and zeroes the counters; stored words are not
// cleared, and no pipeline stage holds a transaction after reset.
// ----------------------------------------------------------------------------
module three_level_priority_queue_top import tlpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [1:0]  priority_req,
	input  logic [31:0] payload,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        ok,
	output logic [31:0] payload_out,
	output logic [1:0]  served_level,
	output logic [31:0] added_low,
	output logic [31:0] added_mid,
	output logic [31:0] added_high,
	output logic [31:0] served_total
);

	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [1:0]        prio_s1;
	logic [DATA_W-1:0] payload_s1;

	logic              rsp_valid_q;
	logic              ok_q;
	logic [31:0]       payload_out_q;
	logic [1:0]        served_level_q;
	logic [CTR_W-1:0]  added_q [NUM_LEVELS];
	logic [CTR_W-1:0]  served_q;

	logic              advance;
	logic              take_req;
	logic [NUM_LEVELS-1:0] push_go;
	logic [NUM_LEVELS-1:0] pop_go;
	logic [DATA_W-1:0] rdata [NUM_LEVELS];
	fifo_stat_t        stat [NUM_LEVELS];

	logic              pop_found;
	level_t            pop_level;
	logic              is_push;
	logic              is_pop;
	logic              is_clear;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign take_req  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_req) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			action_s1  <= action;
			prio_s1    <= priority_req;
			payload_s1 <= payload[DATA_W-1:0];
		end
	end

	assign is_push  = (action_s1 == ACT_PUSH);
	assign is_pop   = (action_s1 == ACT_POP);
	assign is_clear = (action_s1 == ACT_CLEAR);

	always_comb begin
		pop_found = 1'b1;
		pop_level = LVL_HIGH;
		if (!stat[LVL_HIGH].empty) begin
			pop_level = LVL_HIGH;
		end else if (!stat[LVL_MID].empty) begin
			pop_level = LVL_MID;
		end else if (!stat[LVL_LOW].empty) begin
			pop_level = LVL_LOW;
		end else begin
			pop_found = 1'b0;
		end
	end

	for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_level
		assign push_go[i] = advance && is_push && (prio_s1 == 2'(i)) && !stat[i].full;
		assign pop_go[i]  = advance && is_pop && pop_found && (pop_level == 2'(i));

		tlpq_fifo u_fifo (
			.clk    (clk),
			.arst_n (arst_n),
			.push   (push_go[i]),
			.pop    (pop_go[i]),
			.wdata  (payload_s1),
			.rdata  (rdata[i]),
			.stat   (stat[i])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				added_q[i] <= '0;
			end else if (advance && is_clear) begin
				added_q[i] <= '0;
			end else if (push_go[i]) begin
				added_q[i] <= added_q[i] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q <= '0;
		end else if (advance && is_clear) begin
			served_q <= '0;
		end else if (|pop_go) begin
			served_q <= served_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_q <= (|push_go) || (|pop_go);
			if (is_pop && pop_found) begin
				payload_out_q  <= 32'(rdata[pop_level]);
				served_level_q <= pop_level;
			end else begin
				payload_out_q  <= '0;
				served_level_q <= LVL_HIGH;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign ok           = ok_q;
	assign payload_out  = payload_out_q;
	assign served_level = served_level_q;
	assign added_high   = added_q[LVL_HIGH];
	assign added_mid    = added_q[LVL_MID];
	assign added_low    = added_q[LVL_LOW];
	assign served_total = served_q;

	a_fail_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> payload_out == '0 && served_level == LVL_HIGH)
		else $error("failed response carries data or a level");

	a_one_queue_op: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({push_go, pop_go}) <= 1)
		else $error("more than one queue operation in a cycle");

	a_counters_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(served_q) && $stable(added_q[LVL_HIGH]))
		else $error("counter changed without a processed transaction");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat[LVL_HIGH].empty && stat[LVL_HIGH].full)
		&& !(stat[LVL_LOW].empty && stat[LVL_LOW].full))
		else $error("queue reports empty and full at once");

endmodule
`default_nettype wire
